[hw/rtl/lkvc_pkg.sv]
// Shared constants and types for the LRU key-value cache.
`timescale 1ns / 1ps
`default_nettype none
package lkvc_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int CAP_BITS   = 5;
	localparam int CNT_BITS   = $clog2(ENTRIES + 1);
	localparam int CMP_BITS   = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} lkvc_op_t;

	// one slot of the recency chain
	typedef struct packed {
		logic                  valid;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} lkvc_entry_t;

	// flows from the least recent cell towards the head
	typedef struct packed {
		logic                  tail_hit;
		logic [VALUE_BITS-1:0] sel_value;
	} lkvc_link_t;

	// broadcast to every cell
	typedef struct packed {
		logic upd;
		logic hit;
		logic evict;
	} lkvc_cmd_t;

endpackage
`default_nettype wire

[hw/rtl/lkvc_cell.sv]
// One recency slot of the cache: compare, hand on and shift.
`timescale 1ns / 1ps
`default_nettype none
module lkvc_cell (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire lkvc_pkg::lkvc_cmd_t       cmd,
	input  wire [lkvc_pkg::KEY_BITS-1:0]   lookup_key,
	input  wire lkvc_pkg::lkvc_entry_t     prev,
	output lkvc_pkg::lkvc_entry_t          own,
	input  wire lkvc_pkg::lkvc_link_t      link_in,
	output lkvc_pkg::lkvc_link_t           link_out
);
	import lkvc_pkg::*;

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  match;
	logic                  shift;

	assign match = valid_q && (key_q == lookup_key);

	assign link_out.tail_hit  = match | link_in.tail_hit;
	assign link_out.sel_value = link_in.sel_value | (match ? value_q : '0);

	always_comb begin
		priority if (!cmd.upd) begin
			shift = 1'b0;
		end else if (cmd.hit) begin
			shift = link_out.tail_hit;
		end else if (cmd.evict) begin
			shift = valid_q;
		end else begin
			shift = prev.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= prev.key;
			value_q <= prev.value;
		end
	end

	assign own.valid = valid_q;
	assign own.key   = key_q;
	assign own.value = value_q;

endmodule
`default_nettype wire

[hw/rtl/lru_key_value_cache_core.sv]
// Top level of the LRU key-value cache: request register, cell chain, result register.
`timescale 1ns / 1ps
`default_nettype none
// Fully associative key-value cache with least-recently-used replacement, held as a
// row of cells ordered by recency (the head cell is the most recent). A request is
// taken into a register, then every cell compares its key, the row shifts by one slot
// up to the hit, insert or victim position, and the result is registered. One request
// per cycle is sustained while the result side does not stall; a result is registered
// when its request leaves the request register, which waits while a registered result
// is stalled. The rate is set by the compare and shift across the cell row. A read miss
// and every write return read_value zero. The capacity register counts 0 as 1 and
// saturates above the number of cells.
module lru_key_value_cache_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [lkvc_pkg::CAP_BITS-1:0]        cfg_wdata,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire                                 opcode,
	input  wire [lkvc_pkg::KEY_BITS-1:0]        lookup_key,
	input  wire [lkvc_pkg::VALUE_BITS-1:0]      write_value,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic                                hit,
	output logic [lkvc_pkg::VALUE_BITS-1:0]     read_value
);
	import lkvc_pkg::*;

	logic [CAP_BITS-1:0]   capacity_limit_q;
	logic [CNT_BITS-1:0]   entry_count_q;
	logic                  item_vld_s1;
	lkvc_op_t              opcode_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic                  out_valid_q;
	logic                  hit_q;
	logic [VALUE_BITS-1:0] read_value_q;

	logic                  advance;
	logic                  found;
	logic                  full;
	logic [CMP_BITS-1:0]   cap_ext;
	logic [CMP_BITS-1:0]   eff_cap;
	logic [VALUE_BITS-1:0] hit_value;
	lkvc_cmd_t             cmd;
	lkvc_entry_t           ent [ENTRIES+1];
	lkvc_link_t            lnk [ENTRIES+1];

	assign advance  = item_vld_s1 && (!out_valid_q || !out_stall);
	assign in_stall = item_vld_s1 && !advance;

	assign cap_ext = CMP_BITS'(capacity_limit_q);
	always_comb begin
		priority if (cap_ext == '0) begin
			eff_cap = CMP_BITS'(1);
		end else if (cap_ext > CMP_BITS'(ENTRIES)) begin
			eff_cap = CMP_BITS'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end
	assign full = CMP_BITS'(entry_count_q) >= eff_cap;

	assign found     = lnk[0].tail_hit;
	assign hit_value = lnk[0].sel_value;

	assign cmd.upd   = advance && (found || (opcode_s1 == OP_WRITE));
	assign cmd.hit   = found;
	assign cmd.evict = !found && full;

	assign ent[0].valid = 1'b1;
	assign ent[0].key   = key_s1;
	assign ent[0].value = (found && (opcode_s1 == OP_READ)) ? hit_value : value_s1;

	assign lnk[ENTRIES] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lkvc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.lookup_key (key_s1),
			.prev       (ent[i]),
			.own        (ent[i+1]),
			.link_in    (lnk[i+1]),
			.link_out   (lnk[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_limit_q <= CAP_RESET;
			entry_count_q    <= '0;
			item_vld_s1      <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_limit_q <= cfg_wdata;
			end
			if (advance && (opcode_s1 == OP_WRITE) && !found && !full) begin
				entry_count_q <= entry_count_q + CNT_BITS'(1);
			end
			if (in_valid && !in_stall) begin
				item_vld_s1 <= 1'b1;
			end else if (advance) begin
				item_vld_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1 <= lkvc_op_t'(opcode);
			key_s1    <= lookup_key;
			value_s1  <= write_value;
		end
		if (advance) begin
			hit_q        <= found;
			read_value_q <= (found && (opcode_s1 == OP_READ)) ? hit_value : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

endmodule
`default_nettype wire

[dv/lkvc_reply_checker.sv]
// Checker for the LRU key-value cache: predicts each reply and compares it with the block.
`timescale 1ns / 1ps
module lkvc_reply_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lkvc_pkg::CAP_BITS-1:0]   cfg_wdata,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic                            opcode,
	input  logic [lkvc_pkg::KEY_BITS-1:0]   lookup_key,
	input  logic [lkvc_pkg::VALUE_BITS-1:0] write_value,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            hit,
	input  logic [lkvc_pkg::VALUE_BITS-1:0] read_value,
	output int                              fail_count,
	output int                              pending
);
	import lkvc_pkg::*;

	typedef struct packed {
		logic                  hit;
		logic [VALUE_BITS-1:0] value;
	} cache_reply_t;

	logic [KEY_BITS-1:0]   slot_key [ENTRIES];
	logic [VALUE_BITS-1:0] slot_value [ENTRIES];
	logic                  slot_used [ENTRIES];
	int unsigned           slot_rank [ENTRIES];
	int unsigned           used_count;
	logic [CAP_BITS-1:0]   capacity;
	cache_reply_t          replies_due [$];
	cache_reply_t          due;
	int                    errs = 0;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	function automatic void bump_to_front(int s, int unsigned old_rank);
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_used[i] && i != s && slot_rank[i] < old_rank)
				slot_rank[i]++;
		end
		slot_rank[s] = 0;
	endfunction

	function automatic cache_reply_t lookup_and_update(lkvc_op_t op, logic [KEY_BITS-1:0] key,
			logic [VALUE_BITS-1:0] value);
		cache_reply_t reply;
		int found;
		int victim;
		int unsigned limit;
		found  = -1;
		victim = -1;
		reply  = '0;
		limit  = capacity;
		if (limit == 0)
			limit = 1;
		if (limit > ENTRIES)
			limit = ENTRIES;
		for (int i = 0; i < ENTRIES; i++) begin
			if (found < 0 && slot_used[i] && slot_key[i] == key)
				found = i;
		end
		if (found >= 0) begin
			reply.hit = 1'b1;
			if (op == OP_WRITE)
				slot_value[found] = value;
			else
				reply.value = slot_value[found];
			bump_to_front(found, slot_rank[found]);
		end else if (op == OP_WRITE) begin
			if (used_count >= limit) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot_used[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
						victim = i;
				end
				slot_key[victim]   = key;
				slot_value[victim] = value;
				bump_to_front(victim, slot_rank[victim]);
			end else begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (victim < 0 && !slot_used[i])
						victim = i;
				end
				slot_used[victim]  = 1'b1;
				slot_key[victim]   = key;
				slot_value[victim] = value;
				bump_to_front(victim, used_count);
				used_count++;
			end
		end
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				slot_used[i]  = 1'b0;
				slot_rank[i]  = 0;
				slot_key[i]   = '0;
				slot_value[i] = '0;
			end
			used_count = 0;
			capacity   = CAP_RESET;
			replies_due.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				capacity = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$error("unexpected word: hit %0b read_value %h", hit, read_value);
					errs++;
				end else begin
					due = replies_due[0];
					replies_due.delete(0);
					if (hit !== due.hit) begin
						$error("hit: expected %0b, got %0b", due.hit, hit);
						errs++;
					end
					if (read_value !== due.value) begin
						$error("read_value: expected %h, got %h", due.value, read_value);
						errs++;
					end
				end
			end
			if (in_valid && !in_stall)
				replies_due.push_back(lookup_and_update(lkvc_op_t'(opcode), lookup_key,
					write_value));
			pending    <= replies_due.size();
			fail_count <= errs;
		end
	end

endmodule

[dv/lru_key_value_cache_core_test.sv]
// Testbench top for the LRU key-value cache: clock, reset, stimulus phases and verdict.
`timescale 1ns / 1ps
module lru_key_value_cache_core_test;
	import lkvc_pkg::*;

	typedef enum int {
		FLOW_FREE,
		FLOW_SEND_SPARSE,
		FLOW_RECV_STALL,
		FLOW_BOTH
	} flow_mode_t;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_WORDS  = 105;
	localparam int PHASES       = 12;

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  cfg_we      = 1'b0;
	logic [CAP_BITS-1:0]   cfg_wdata   = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic                  opcode      = 1'b0;
	logic [KEY_BITS-1:0]   lookup_key  = '0;
	logic [VALUE_BITS-1:0] write_value = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic                  hit;
	logic [VALUE_BITS-1:0] read_value;
	int                    fail_count;
	int                    pending;
	int                    cycle_count = 0;
	flow_mode_t            flow        = FLOW_FREE;

	lru_key_value_cache_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.read_value  (read_value)
	);

	lkvc_reply_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.read_value  (read_value),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		unique case (flow)
			FLOW_RECV_STALL: out_stall <= ($urandom_range(99) < 83);
			FLOW_BOTH:       out_stall <= ($urandom_range(99) < 33);
			default:         out_stall <= 1'b0;
		endcase
	end

	// drain, then write capacity with the block idle
	task automatic configure(logic [CAP_BITS-1:0] cap, flow_mode_t mode);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		flow      <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_word(lkvc_op_t op, logic [KEY_BITS-1:0] key,
			logic [VALUE_BITS-1:0] value);
		int gap_pct;
		gap_pct = (flow == FLOW_SEND_SPARSE) ? 83 : (flow == FLOW_BOTH) ? 33 : 0;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		lookup_key  <= key;
		write_value <= value;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic run_phase(logic [CAP_BITS-1:0] cap, flow_mode_t mode, int words);
		logic [KEY_BITS-1:0] key_pool [24];
		logic [KEY_BITS-1:0] key;
		int span;
		configure(cap, mode);
		span = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
		span = (span + 4 > 24) ? 24 : span + 4;
		foreach (key_pool[i])
			key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int k = 0; k < words; k++) begin
			if ($urandom_range(99) < 8)
				key = $urandom;
			else
				key = key_pool[$urandom_range(span - 1)];
			send_word($urandom_range(1) ? OP_WRITE : OP_READ, key, $urandom);
		end
	endtask

	initial begin
		logic [CAP_BITS-1:0] phase_caps [PHASES];
		phase_caps = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd17, 5'd2, 5'd16, 5'd3, 5'd0, 5'd8,
			5'd31, 5'd5};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(5'd16, FLOW_FREE);
		send_word(OP_READ,  32'h0000_0000, 32'hFFFF_FFFF);
		send_word(OP_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
		send_word(OP_READ,  32'h0000_0000, 32'h0000_0000);
		send_word(OP_WRITE, 32'hFFFF_FFFF, 32'h0000_0000);
		send_word(OP_READ,  32'hFFFF_FFFF, 32'h1234_5678);
		send_word(OP_WRITE, 32'h0000_0000, 32'hA5A5_A5A5);
		send_word(OP_READ,  32'h0000_0000, 32'h0000_0000);
		send_word(OP_READ,  32'h1234_5678, 32'hFFFF_FFFF);

		configure(5'd2, FLOW_FREE);
		send_word(OP_WRITE, 32'h0000_0001, 32'h0000_0011);
		send_word(OP_WRITE, 32'h0000_0002, 32'h0000_0022);
		send_word(OP_READ,  32'h0000_0001, 32'h0000_0000);
		send_word(OP_WRITE, 32'h0000_0003, 32'h0000_0033);
		send_word(OP_READ,  32'h0000_0002, 32'h0000_0000);
		send_word(OP_READ,  32'h0000_0001, 32'h0000_0000);
		send_word(OP_READ,  32'h0000_0003, 32'h0000_0000);

		configure(5'd0, FLOW_FREE);
		send_word(OP_WRITE, 32'h0000_0007, 32'h0000_0077);
		send_word(OP_READ,  32'h0000_0007, 32'h0000_0000);
		send_word(OP_WRITE, 32'h0000_0008, 32'h0000_0088);
		send_word(OP_READ,  32'h0000_0007, 32'h0000_0000);
		send_word(OP_READ,  32'h0000_0008, 32'h0000_0000);

		for (int p = 0; p < PHASES; p++)
			run_phase(phase_caps[p], flow_mode_t'(p % 4), PHASE_WORDS);

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_cell.sv
hw/rtl/lru_key_value_cache_core.sv
dv/lkvc_reply_checker.sv
dv/lru_key_value_cache_core_test.sv
